// File: src/fird_pkg.sv
`default_nettype none

package fird_pkg;

    localparam int MAX_TAPS_DEF = 2048;

    localparam int REQ_W       = 2;
    localparam int SAMPLE_W    = 16;
    localparam int IDX_W       = 11;
    localparam int COEF_W      = 18;
    localparam int TAP_CNT_W   = 12;
    localparam int PROD_W      = SAMPLE_W + COEF_W;

    localparam int SAMPLE_LSB  = 0;
    localparam int IDX_LSB     = SAMPLE_LSB + SAMPLE_W;
    localparam int COEF_LSB    = IDX_LSB + IDX_W;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 16;

    localparam int RND_SHIFT   = 16;

    typedef enum logic [REQ_W-1:0] {
        REQ_SAMPLE   = 2'd0,
        REQ_COEF_WR  = 2'd1,
        REQ_CLR_DLY  = 2'd2,
        REQ_CLR_COEF = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic clear;
        logic mul_en;
    } t_mac_ctl;

endpackage

`default_nettype wire

// File: src/fird_mac.sv
`default_nettype none

module fird_mac
    import fird_pkg::*;
#(
    parameter int ACC_W = PROD_W + 13
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_mac_ctl                   i_ctl,
    input  wire logic signed [SAMPLE_W-1:0] i_x,
    input  wire logic signed [COEF_W-1:0]   i_coef,
    output logic                            o_busy,
    output logic signed [SAMPLE_W-1:0]      o_y
);

    localparam int Q_W = ACC_W - RND_SHIFT;

    logic signed [PROD_W-1:0] x_ext;
    logic signed [PROD_W-1:0] c_ext;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_v2;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [Q_W-1:0]    q;

    assign x_ext = PROD_W'(i_x);
    assign c_ext = PROD_W'(i_coef);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= i_ctl.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= x_ext * c_ext;
        end
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // round to nearest, ties up, then saturate
    always_comb begin
        rnd = r_acc + ACC_W'(32768);
        q   = rnd[ACC_W-1:RND_SHIFT];
        if (q > $signed(Q_W'(32767))) begin
            o_y = 16'sh7fff;
        end else if (q < $signed(-Q_W'(32768))) begin
            o_y = -16'sh8000;
        end else begin
            o_y = q[SAMPLE_W-1:0];
        end
    end

    assign o_busy = r_v2;

endmodule

`default_nettype wire

// File: src/fir_filter_direct_form.sv
// Direct-form FIR filter with one shared multiply-accumulate unit.
// Input stream: i_s_axis_tuser carries the request kind (sample, coefficient
// write, clear delay line, clear coefficients); i_s_axis_tdata carries the
// sample, coefficient index and coefficient value. Output stream: one
// filtered Q1.15 sample per sample request, none for the other kinds.
// i_cfg_we / i_cfg_wdata set the tap count (reset 1, values above MAX_TAPS
// act as MAX_TAPS); write it only while the filter is idle.
// A sample request runs one tap per cycle through the single multiplier,
// reading one coefficient and one delay entry per cycle; the filter then
// waits for the MAC to drain and loads the result into the output register
// (with zero taps it goes straight to that load). The input is not ready
// meanwhile, so a new sample is taken only after the result is loaded. A
// coefficient write is taken while idle and leaves the filter idle. Each
// clear request sweeps its memory one entry per cycle, all MAX_TAPS entries.
// After reset both memories are swept to zero, all MAX_TAPS entries, before
// the first request is taken. The result sits in an output register: a new
// request is accepted while it waits, but the next result is held back
// until the receiver has taken the previous one.
`default_nettype none

module fir_filter_direct_form
    import fird_pkg::*;
#(
    parameter int MAX_TAPS = MAX_TAPS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [TAP_CNT_W-1:0]  i_cfg_wdata,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // sample_in, coef_index, coef_value, zero fill
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // req_type
    input  wire logic [REQ_W-1:0]      i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // filtered_sample
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata
);

    localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int ACC_W = PROD_W + CNT_W + 1;

    t_state                    r_state, n_state;
    logic [TAP_CNT_W-1:0]      r_tap_count;
    logic [CNT_W-1:0]          r_idx, n_idx;
    logic [CNT_W-1:0]          r_taps;
    logic [CNT_W-1:0]          taps_eff;
    logic [CNT_W-1:0]          idx_m1;
    logic                      r_clr_dly, n_clr_dly;
    logic                      r_clr_coef, n_clr_coef;
    logic                      r_v1;
    logic                      r_first1;
    logic [AW-1:0]             r_waddr;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [SAMPLE_W-1:0] r_carry;
    logic                      r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0]     r_out;

    logic signed [SAMPLE_W-1:0] dly_mem [MAX_TAPS];
    logic signed [COEF_W-1:0]   coef_mem [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] r_dly_q;
    logic signed [COEF_W-1:0]   r_coef_q;

    t_req                      in_req;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic [IDX_W-1:0]          in_index;
    logic signed [COEF_W-1:0]  in_coef;
    logic                      in_xfer;
    logic                      idx_ok;

    logic                      coef_we;
    logic [AW-1:0]             coef_waddr;
    logic signed [COEF_W-1:0]  coef_wdata;
    logic                      dly_we;
    logic [AW-1:0]             dly_waddr;
    logic signed [SAMPLE_W-1:0] dly_wdata;

    t_mac_ctl                  mac_ctl;
    logic                      mac_busy;
    logic signed [SAMPLE_W-1:0] mac_y;
    logic signed [SAMPLE_W-1:0] mul_x;
    logic                      load_out;

    assign in_req    = t_req'(i_s_axis_tuser);
    assign in_sample = i_s_axis_tdata[SAMPLE_LSB +: SAMPLE_W];
    assign in_index  = i_s_axis_tdata[IDX_LSB +: IDX_W];
    assign in_coef   = i_s_axis_tdata[COEF_LSB +: COEF_W];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign idx_ok          = (32'(in_index) < 32'(MAX_TAPS));
    assign taps_eff        = (32'(r_tap_count) > 32'(MAX_TAPS)) ?
                             CNT_W'(MAX_TAPS) : CNT_W'(r_tap_count);
    assign idx_m1          = r_idx - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_CNT_W'(1);
        end else if (i_cfg_we) begin
            r_tap_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_idx       <= '0;
            r_clr_dly   <= 1'b1;
            r_clr_coef  <= 1'b1;
            r_out_valid <= 1'b0;
            r_v1        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_clr_dly   <= n_clr_dly;
            r_clr_coef  <= n_clr_coef;
            r_out_valid <= n_out_valid;
            r_v1        <= (r_state == ST_RUN);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_clr_dly   = r_clr_dly;
        n_clr_coef  = r_clr_coef;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        load_out    = 1'b0;
        mac_ctl     = '0;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_idx == CNT_W'(MAX_TAPS - 1)) begin
                    n_state    = ST_IDLE;
                    n_idx      = '0;
                    n_clr_dly  = 1'b0;
                    n_clr_coef = 1'b0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    n_idx = '0;
                    unique case (in_req)
                        REQ_SAMPLE: begin
                            mac_ctl.clear = 1'b1;
                            n_state = (taps_eff == '0) ? ST_FINISH : ST_RUN;
                        end
                        REQ_COEF_WR: begin
                            n_state = ST_IDLE;
                        end
                        REQ_CLR_DLY: begin
                            n_state   = ST_CLEAR;
                            n_clr_dly = 1'b1;
                        end
                        REQ_CLR_COEF: begin
                            n_state    = ST_CLEAR;
                            n_clr_coef = 1'b1;
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (r_idx == r_taps - 1'b1) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!r_v1 && !mac_busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        mac_ctl.mul_en = r_v1;
    end

    // sample operand and pending shift value
    always_ff @(posedge i_clk) begin
        if (in_xfer && in_req == REQ_SAMPLE) begin
            r_x     <= in_sample;
            r_carry <= in_sample;
            r_taps  <= taps_eff;
        end else if (r_v1 && !r_first1) begin
            r_carry <= r_dly_q;
        end
        r_first1 <= (r_idx == '0);
        r_waddr  <= idx_m1[AW-1:0];
        if (load_out) begin
            r_out <= mac_y;
        end
    end

    assign mul_x = r_first1 ? r_x : r_dly_q;

    always_comb begin
        coef_we    = 1'b0;
        coef_waddr = AW'(in_index);
        coef_wdata = in_coef;
        if (r_state == ST_CLEAR) begin
            coef_we    = r_clr_coef;
            coef_waddr = r_idx[AW-1:0];
            coef_wdata = '0;
        end else if (in_xfer && in_req == REQ_COEF_WR && idx_ok) begin
            coef_we = 1'b1;
        end
    end

    always_comb begin
        dly_we    = 1'b0;
        dly_waddr = r_waddr;
        dly_wdata = r_carry;
        if (r_state == ST_CLEAR) begin
            dly_we    = r_clr_dly;
            dly_waddr = r_idx[AW-1:0];
            dly_wdata = '0;
        end else if (r_v1 && !r_first1) begin
            dly_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (coef_we) begin
            coef_mem[coef_waddr] <= coef_wdata;
        end
        r_coef_q <= coef_mem[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (dly_we) begin
            dly_mem[dly_waddr] <= dly_wdata;
        end
        r_dly_q <= dly_mem[idx_m1[AW-1:0]];
    end

    fird_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_x     (mul_x),
        .i_coef  (r_coef_q),
        .o_busy  (mac_busy),
        .o_y     (mac_y)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

endmodule

`default_nettype wire
